// ===== rtl/sparse_matrix_element_store_core_assert.svh =====
// assertion macros shared by the store core
`ifndef SPARSE_MATRIX_ELEMENT_STORE_CORE_ASSERT_SVH
`define SPARSE_MATRIX_ELEMENT_STORE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SMES_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smes assertion failed");
// next-cycle implication
`define SMES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smes assertion failed");
`else
`define SMES_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SMES_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/smes_pkg.sv =====
package smes_pkg;

    // request codes
    localparam logic [1:0] ACT_WRITE  = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;

    // configuration register indexes
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    // dimension registers
    localparam int unsigned CFG_BITS = 11;
    localparam logic [CFG_BITS-1:0] CFG_DIM_RESET = 11'd1024;

    // hard limit on any index
    localparam logic [16:0] C_MAX_DIM = 17'd1024;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_RANGE   = 2'd1,
        STATUS_MISSING = 2'd2,
        STATUS_FULL    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic [1:0]         action;
        logic [9:0]         row;
        logic [9:0]         col;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] read_value;
    } t_out_item;

    // search token handed from cell to cell
    typedef struct packed {
        logic       active;
        logic [9:0] row;
        logic [9:0] col;
        logic       found;
        logic       free_seen;
    } t_scan;

    // write-back command broadcast to all cells
    typedef struct packed {
        logic       en;
        logic [1:0] action;
        logic       found;
        logic [9:0] row;
        logic [9:0] col;
    } t_commit;

endpackage

// ===== rtl/sparse_matrix_element_store_core.sv =====
// a request is taken only in the idle state, so a new one waits until the last has committed;
// an index out of range skips the search; otherwise the search token walks the row of
//   entry cells one cell per cycle, then a write-back updates the chosen cell
// reset: synchronous active low; all entries invalid, both dimensions 1024
// a finished result waits in the output register while the next request is taken
`include "sparse_matrix_element_store_core_assert.svh"

module sparse_matrix_element_store_core #(
    parameter int MAX_ENTRIES = 64,
    parameter int VALUE_BITS  = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  smes_pkg::t_in_item         i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output smes_pkg::t_out_item        o_out_data,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic                       i_cfg_index,
    input  logic [smes_pkg::CFG_BITS-1:0] i_cfg_data
);
    import smes_pkg::*;

    t_state                r_state;
    t_state                n_state;
    logic [CFG_BITS-1:0]   r_rows;
    logic [CFG_BITS-1:0]   r_cols;
    t_in_item              r_req;
    logic                  r_range;
    logic                  r_found;
    logic                  r_free_seen;
    logic [VALUE_BITS-1:0] r_found_val;
    t_scan                 r_head;
    logic                  r_out_valid;
    t_out_item             r_out_data;

    t_scan                 scan_tok [MAX_ENTRIES+1];
    logic [VALUE_BITS-1:0] scan_val [MAX_ENTRIES+1];

    logic                  in_acc;
    logic                  out_free;
    logic                  in_range_err;
    logic                  commit_go;
    t_commit               commit;
    logic [VALUE_BITS-1:0] wr_val;
    t_out_item             n_out_data;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // index check against configured and hard dimensions
    assign in_range_err = ({1'b0, i_in_data.row} >= r_rows)
                       || (17'(i_in_data.row) >= C_MAX_DIM)
                       || ({1'b0, i_in_data.col} >= r_cols)
                       || (17'(i_in_data.col) >= C_MAX_DIM);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = in_range_err ? ST_COMMIT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_tok[MAX_ENTRIES].active) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = 1'b0;
        commit_go  = 1'b0;
        unique case (r_state)
            ST_IDLE:   o_in_ready = 1'b1;
            ST_SCAN:   ;
            ST_COMMIT: commit_go = out_free;
            default:   ;
        endcase
    end

    // write-back command and stored form of the value
    assign wr_val       = VALUE_BITS'($unsigned(r_req.value));
    assign commit.en     = commit_go && !r_range;
    assign commit.action = r_req.action;
    assign commit.found  = r_found;
    assign commit.row    = r_req.row;
    assign commit.col    = r_req.col;

    // result of the finished request
    always_comb begin
        n_out_data.status     = STATUS_OK;
        n_out_data.read_value = '0;
        if (r_range) begin
            n_out_data.status = STATUS_RANGE;
        end else begin
            unique case (r_req.action)
                ACT_WRITE: begin
                    n_out_data.status = (r_found || r_free_seen) ? STATUS_OK : STATUS_FULL;
                end
                ACT_REMOVE: begin
                    n_out_data.status = r_found ? STATUS_OK : STATUS_MISSING;
                end
                default: begin
                    n_out_data.status = r_found ? STATUS_OK : STATUS_MISSING;
                    if (r_found) begin
                        n_out_data.read_value = 32'(r_found_val);
                    end
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rows      <= CFG_DIM_RESET;
            r_cols      <= CFG_DIM_RESET;
            r_head      <= '0;
            r_out_valid <= 1'b0;
            r_range     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_ROWS: r_rows <= i_cfg_data;
                    CFG_COLS: r_cols <= i_cfg_data;
                    default:  ;
                endcase
            end
            r_head.active <= in_acc && !in_range_err;
            r_head.row    <= i_in_data.row;
            r_head.col    <= i_in_data.col;
            r_head.found     <= 1'b0;
            r_head.free_seen <= 1'b0;
            if (in_acc) begin
                r_range <= in_range_err;
            end
            if (commit_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // held request, tail of the scan and result payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req <= i_in_data;
        end
        if (scan_tok[MAX_ENTRIES].active) begin
            r_found     <= scan_tok[MAX_ENTRIES].found;
            r_free_seen <= scan_tok[MAX_ENTRIES].free_seen;
            r_found_val <= scan_val[MAX_ENTRIES];
        end
        if (commit_go) begin
            r_out_data <= n_out_data;
        end
    end

    // row of entry cells
    assign scan_tok[0] = r_head;
    assign scan_val[0] = '0;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        smes_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_scan     (scan_tok[g]),
            .i_scan_val (scan_val[g]),
            .o_scan     (scan_tok[g+1]),
            .o_scan_val (scan_val[g+1]),
            .i_commit   (commit),
            .i_wr_val   (wr_val)
        );
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // checks on sequencing
    `SMES_ASSERT_IMPL(a_result_after_commit, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == ST_COMMIT))
    `SMES_ASSERT_IMPL(a_tail_only_in_scan, i_clk, i_rst_n, scan_tok[MAX_ENTRIES].active, r_state == ST_SCAN)
    `SMES_ASSERT_NEXT(a_range_skips_scan, i_clk, i_rst_n, in_acc && in_range_err, r_state == ST_COMMIT && !r_head.active)

endmodule

// ===== rtl/smes_cell.sv =====
module smes_cell #(
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  smes_pkg::t_scan       i_scan,
    input  logic [VALUE_BITS-1:0] i_scan_val,
    output smes_pkg::t_scan       o_scan,
    output logic [VALUE_BITS-1:0] o_scan_val,
    input  smes_pkg::t_commit     i_commit,
    input  logic [VALUE_BITS-1:0] i_wr_val
);
    import smes_pkg::*;

    logic                  r_valid;
    logic [9:0]            r_row;
    logic [9:0]            r_col;
    logic [VALUE_BITS-1:0] r_value;
    logic                  r_match;
    logic                  r_first_free;
    t_scan                 r_scan;
    logic [VALUE_BITS-1:0] r_scan_val;

    logic                  hit;
    t_scan                 n_scan;
    logic [VALUE_BITS-1:0] n_scan_val;
    logic                  do_update;
    logic                  do_claim;
    logic                  do_clear;

    // compare the passing token against this entry
    assign hit = i_scan.active && r_valid && (r_row == i_scan.row) && (r_col == i_scan.col);

    always_comb begin
        n_scan = i_scan;
        if (i_scan.active) begin
            n_scan.found     = i_scan.found | hit;
            n_scan.free_seen = i_scan.free_seen | ~r_valid;
        end
        n_scan_val = hit ? r_value : i_scan_val;
    end

    // write-back decisions from the marks left by the scan
    always_comb begin
        do_update = 1'b0;
        do_claim  = 1'b0;
        do_clear  = 1'b0;
        if (i_commit.en) begin
            unique case (i_commit.action)
                ACT_WRITE: begin
                    do_update = i_commit.found & r_match;
                    do_claim  = ~i_commit.found & r_first_free;
                end
                ACT_REMOVE: begin
                    do_clear = r_match;
                end
                default: begin
                end
            endcase
        end
    end

    // control state: valid bit, scan marks, token
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_match      <= 1'b0;
            r_first_free <= 1'b0;
            r_scan       <= '0;
        end else begin
            r_scan <= n_scan;
            if (i_scan.active) begin
                r_match      <= hit;
                r_first_free <= ~r_valid & ~i_scan.free_seen;
            end
            if (do_claim) begin
                r_valid <= 1'b1;
            end else if (do_clear) begin
                r_valid <= 1'b0;
            end
        end
    end

    // entry payload and forwarded value
    always_ff @(posedge i_clk) begin
        r_scan_val <= n_scan_val;
        if (do_claim) begin
            r_row <= i_commit.row;
            r_col <= i_commit.col;
        end
        if (do_claim || do_update) begin
            r_value <= i_wr_val;
        end
    end

    assign o_scan     = r_scan;
    assign o_scan_val = r_scan_val;

endmodule

// ===== sim/sparse_matrix_element_store_core_test.sv =====
module sparse_matrix_element_store_core_test;
    import smes_pkg::*;

    localparam int MAX_ENTRIES = 64;
    localparam int VALUE_BITS = 32;
    // one request walks every entry cell, then commits
    localparam int SETTLE_CYCLES = MAX_ENTRIES + 8;
    localparam int CYCLE_LIMIT = 400000;
    // action code that the block treats as a read
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in_item i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b1;
    t_out_item o_out_data;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic i_cfg_index = CFG_ROWS;
    logic [CFG_BITS-1:0] i_cfg_data = '0;

    // predicted contents of the element table and the dimension registers
    logic store_valid [MAX_ENTRIES];
    logic [9:0] store_row [MAX_ENTRIES];
    logic [9:0] store_col [MAX_ENTRIES];
    logic signed [VALUE_BITS-1:0] store_value [MAX_ENTRIES];
    logic [CFG_BITS-1:0] row_limit = CFG_DIM_RESET;
    logic [CFG_BITS-1:0] col_limit = CFG_DIM_RESET;

    t_out_item pending_results [$];
    int mismatch_count = 0;
    int result_count = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int stall_stretch = 0;

    sparse_matrix_element_store_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            store_valid[i] = 1'b0;
        end
    end

    // lookup, insert and removal as the table should perform them
    function automatic t_out_item predict_request(input t_in_item req);
        t_out_item res;
        int hit;
        int vacant;
        res.status = STATUS_OK;
        res.read_value = '0;
        hit = -1;
        vacant = -1;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (store_valid[i] && store_row[i] == req.row && store_col[i] == req.col && hit < 0)
                hit = i;
            if (!store_valid[i] && vacant < 0)
                vacant = i;
        end
        if (req.row >= row_limit || req.row >= C_MAX_DIM ||
            req.col >= col_limit || req.col >= C_MAX_DIM) begin
            res.status = STATUS_RANGE;
        end else begin
            case (req.action)
                ACT_WRITE: begin
                    if (hit >= 0) begin
                        store_value[hit] = req.value;
                    end else if (vacant < 0) begin
                        res.status = STATUS_FULL;
                    end else begin
                        store_valid[vacant] = 1'b1;
                        store_row[vacant] = req.row;
                        store_col[vacant] = req.col;
                        store_value[vacant] = req.value;
                    end
                end
                ACT_REMOVE: begin
                    if (hit < 0)
                        res.status = STATUS_MISSING;
                    else
                        store_valid[hit] = 1'b0;
                end
                default: begin
                    if (hit < 0)
                        res.status = STATUS_MISSING;
                    else
                        res.read_value = store_value[hit];
                end
            endcase
        end
        return res;
    endfunction

    function automatic int live_entries();
        int n;
        n = 0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (store_valid[i])
                n++;
        end
        return n;
    endfunction

    function automatic t_in_item make_request(input logic [1:0] action, input logic [9:0] row,
                                              input logic [9:0] col, input logic [31:0] value);
        t_in_item req;
        req.action = action;
        req.row = row;
        req.col = col;
        req.value = value;
        return req;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endtask

    // offer one request, predict it on transfer, then maybe go idle
    task automatic send_request(input t_in_item req);
        i_in_valid <= 1'b1;
        i_in_data <= req;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(predict_request(req));
        if ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
    endtask

    // hold the input until every predicted result has been taken
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write both dimension registers back to back while the block is idle
    task automatic configure_dims(input logic [CFG_BITS-1:0] rows,
                                  input logic [CFG_BITS-1:0] cols);
        wait_for_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_ROWS;
        i_cfg_data <= rows;
        do @(posedge i_clk); while (!o_cfg_ready);
        row_limit = rows;
        i_cfg_index <= CFG_COLS;
        i_cfg_data <= cols;
        do @(posedge i_clk); while (!o_cfg_ready);
        col_limit = cols;
        i_cfg_valid <= 1'b0;
    endtask

    // result check and receiver stalls
    always @(posedge i_clk) begin : result_check
        t_out_item expected;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            result_count++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result %0d: no request outstanding, got status %0d",
                                          result_count, o_out_data.status));
            end else begin
                expected = pending_results.pop_front();
                if (o_out_data.status !== expected.status)
                    report_mismatch($sformatf("result %0d: status expected %0d got %0d",
                                              result_count, expected.status,
                                              o_out_data.status));
                if (o_out_data.read_value !== expected.read_value)
                    report_mismatch($sformatf("result %0d: read_value expected %0d got %0d",
                                              result_count, expected.read_value,
                                              o_out_data.read_value));
            end
        end
        if (stall_stretch > 0) begin
            stall_stretch = stall_stretch - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // requests to an empty table
    task automatic test_absent_elements();
        send_request(make_request(ACT_READ, 10'd0, 10'd0, 32'h0));
        send_request(make_request(ACT_REMOVE, 10'd1023, 10'd1023, 32'hffff_ffff));
        send_request(make_request(ACT_UNUSED, 10'd5, 10'd5, 32'h1234_5678));
    endtask

    // extreme values, update in place, removal and the unused action code
    task automatic test_extreme_values();
        send_request(make_request(ACT_WRITE, 10'd0, 10'd0, 32'h8000_0000));
        send_request(make_request(ACT_WRITE, 10'd1023, 10'd1023, 32'h7fff_ffff));
        send_request(make_request(ACT_READ, 10'd0, 10'd0, 32'h0));
        send_request(make_request(ACT_READ, 10'd1023, 10'd1023, 32'h0));
        send_request(make_request(ACT_UNUSED, 10'd1023, 10'd1023, 32'h0));
        send_request(make_request(ACT_WRITE, 10'd0, 10'd0, 32'hffff_ffff));
        send_request(make_request(ACT_READ, 10'd0, 10'd0, 32'h0));
        send_request(make_request(ACT_REMOVE, 10'd0, 10'd0, 32'h0));
        send_request(make_request(ACT_READ, 10'd0, 10'd0, 32'h0));
        send_request(make_request(ACT_REMOVE, 10'd0, 10'd0, 32'h0));
    endtask

    // smallest nonzero and largest dimension settings
    task automatic test_index_range();
        configure_dims(11'd1, 11'd1);
        send_request(make_request(ACT_WRITE, 10'd1, 10'd0, 32'h1));
        send_request(make_request(ACT_WRITE, 10'd0, 10'd1, 32'h2));
        send_request(make_request(ACT_WRITE, 10'd0, 10'd0, 32'h3));
        send_request(make_request(ACT_READ, 10'd0, 10'd0, 32'h0));
        configure_dims(11'd2047, 11'd2047);
        send_request(make_request(ACT_WRITE, 10'd1023, 10'd0, 32'h5a5a_a5a5));
        send_request(make_request(ACT_READ, 10'd1023, 10'd0, 32'h0));
    endtask

    // a dimension of zero rejects every index
    task automatic test_zero_dimension();
        configure_dims(11'd0, 11'd1024);
        send_request(make_request(ACT_READ, 10'd0, 10'd0, 32'h0));
        configure_dims(11'd1024, 11'd0);
        send_request(make_request(ACT_WRITE, 10'd0, 10'd0, 32'h7));
        configure_dims(11'd1024, 11'd1024);
    endtask

    // fill every slot, then writes of new elements must be refused until one is removed
    task automatic test_store_full();
        logic [9:0] fill_row;
        fill_row = 10'd512;
        while (live_entries() < MAX_ENTRIES) begin
            send_request(make_request(ACT_WRITE, fill_row, ~fill_row, $urandom));
            fill_row++;
        end
        send_request(make_request(ACT_WRITE, 10'd700, 10'd5, $urandom));
        send_request(make_request(ACT_WRITE, 10'd1023, 10'd1, $urandom));
        send_request(make_request(ACT_WRITE, 10'd512, ~10'd512, $urandom));
        send_request(make_request(ACT_READ, 10'd513, ~10'd513, 32'h0));
        send_request(make_request(ACT_REMOVE, 10'd520, ~10'd520, 32'h0));
        send_request(make_request(ACT_WRITE, 10'd700, 10'd5, $urandom));
        send_request(make_request(ACT_WRITE, 10'd701, 10'd5, $urandom));
        send_request(make_request(ACT_READ, 10'd700, 10'd5, 32'h0));
        send_request(make_request(ACT_REMOVE, 10'd700, 10'd5, 32'h0));
    endtask

    // receiver holds off for a long stretch so the input backs up
    task automatic test_output_backpressure();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        stall_stretch = 300;
        for (int k = 0; k < 8; k++) begin
            send_request(make_request(k[0] ? ACT_READ : ACT_WRITE, 10'd40 + k[9:0] / 2,
                                      10'd3, $urandom));
        end
        wait_for_results();
    endtask

    // random traffic aimed mostly at live elements and a small crowded region
    task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                       input logic [CFG_BITS-1:0] rows,
                                       input logic [CFG_BITS-1:0] cols, input int count);
        t_in_item req;
        int pick;
        int slot;
        configure_dims(rows, cols);
        sender_idle_pct = sender_pct;
        receiver_stall_pct = receiver_pct;
        repeat (count) begin
            pick = $urandom_range(99);
            req.action = pick < 40 ? ACT_WRITE : pick < 70 ? ACT_REMOVE :
                         pick < 95 ? ACT_READ : ACT_UNUSED;
            req.value = $urandom;
            pick = $urandom_range(99);
            slot = $urandom_range(MAX_ENTRIES - 1);
            if (pick < 55 && store_valid[slot]) begin
                req.row = store_row[slot];
                req.col = store_col[slot];
            end else if (pick < 85) begin
                req.row = 10'($urandom_range(7));
                req.col = 10'($urandom_range(7));
            end else begin
                req.row = 10'($urandom_range(1023));
                req.col = 10'($urandom_range(1023));
            end
            send_request(req);
        end
    endtask

    // run limit
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("sparse_matrix_element_store_core_test failed");
        $finish;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_absent_elements();
        test_extreme_values();
        test_index_range();
        test_zero_dimension();
        test_store_full();
        test_output_backpressure();
        test_random_traffic(0, 0, 11'd1024, 11'd1024, 75);
        test_random_traffic(62, 0, 11'd2047, 11'd64, 75);
        test_random_traffic(0, 62, 11'd16, 11'd1024, 75);
        test_random_traffic(25, 25, 11'd1024, 11'd1024, 75);
        receiver_stall_pct = 0;
        wait_for_results();
        if (mismatch_count == 0) begin
            $display("sparse_matrix_element_store_core_test passed");
        end else begin
            $display("sparse_matrix_element_store_core_test failed");
        end
        $finish;
    end

endmodule
